// ===== design/mspi_pkg.sv =====
// Shared types, constants and the microcode table of the motor speed PI controller.
`default_nettype none
package mspi_pkg;

  localparam int INTEGRAL_WIDTH_DEF = 48;
  localparam int PWM_MAX_DEF        = 65535;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_TO_SPEED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TARGET     = 3'd4;

  localparam logic [30:0] TICK_PERIOD_RST    = 31'd16777;
  localparam logic [30:0] COUNT_TO_SPEED_RST = 31'd201061;

  typedef struct packed {
    logic [31:0] prop_gain;
    logic [31:0] integ_gain;
    logic [30:0] tick_period;
    logic [30:0] count_to_speed;
    logic [30:0] max_target;
  } cfg_regs_t;

  // multiplier operand selection
  localparam logic [2:0] MUL_NONE  = 3'd0;
  localparam logic [2:0] MUL_TGT   = 3'd1;  // max_target * speed_ratio
  localparam logic [2:0] MUL_MEAS  = 3'd2;  // encoder_count * count_to_speed
  localparam logic [2:0] MUL_DT    = 3'd3;  // error sum * tick_period
  localparam logic [2:0] MUL_KP    = 3'd4;  // prop_gain * error
  localparam logic [2:0] MUL_KI_LO = 3'd5;  // integ_gain * integral[31:0]
  localparam logic [2:0] MUL_KI_HI = 3'd6;  // integ_gain * integral >>> 32

  // accumulator operations
  localparam logic [1:0] ACC_NONE    = 2'd0;
  localparam logic [1:0] ACC_LOAD    = 2'd1;
  localparam logic [1:0] ACC_ADD     = 2'd2;
  localparam logic [1:0] ACC_ADD_HI  = 2'd3;  // add product shifted up 32

  // stall conditions: the step holds while the condition is true
  localparam logic [1:0] WC_NONE     = 2'd0;
  localparam logic [1:0] WC_NO_START = 2'd1;
  localparam logic [1:0] WC_OUT_BUSY = 2'd2;

  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] STEP_WAIT   = 4'd0;
  localparam logic [PC_W-1:0] STEP_MUL_TR = 4'd1;
  localparam logic [PC_W-1:0] STEP_MUL_CM = 4'd2;
  localparam logic [PC_W-1:0] STEP_ERR    = 4'd3;
  localparam logic [PC_W-1:0] STEP_ESUM   = 4'd4;
  localparam logic [PC_W-1:0] STEP_MUL_DT = 4'd5;
  localparam logic [PC_W-1:0] STEP_INTEG  = 4'd6;
  localparam logic [PC_W-1:0] STEP_MUL_KP = 4'd7;
  localparam logic [PC_W-1:0] STEP_ACC_KP = 4'd8;
  localparam logic [PC_W-1:0] STEP_ACC_KL = 4'd9;
  localparam logic [PC_W-1:0] STEP_ACC_KH = 4'd10;
  localparam logic [PC_W-1:0] STEP_OUT    = 4'd11;

  typedef struct packed {
    logic [2:0]      mul_op;
    logic            ld_in;
    logic            ld_tgt;
    logic            ld_err;
    logic            ld_esum;
    logic            ld_integ;
    logic [1:0]      acc_op;
    logic            ld_out;
    logic [1:0]      wait_cond;
    logic            jmp;
    logic [PC_W-1:0] target;
  } ucode_word_t;

  typedef struct packed {
    ucode_word_t cw;
    logic        fire;  // step executes this cycle
  } seq_ctrl_t;

  function automatic ucode_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_word_t w;
    w = '0;
    case (pc)
      STEP_WAIT: begin
        w.wait_cond = WC_NO_START;
        w.ld_in     = 1'b1;
      end
      STEP_MUL_TR: w.mul_op = MUL_TGT;
      STEP_MUL_CM: begin
        w.ld_tgt = 1'b1;
        w.mul_op = MUL_MEAS;
      end
      STEP_ERR:    w.ld_err = 1'b1;
      STEP_ESUM:   w.ld_esum = 1'b1;
      STEP_MUL_DT: w.mul_op = MUL_DT;
      STEP_INTEG:  w.ld_integ = 1'b1;
      STEP_MUL_KP: w.mul_op = MUL_KP;
      STEP_ACC_KP: begin
        w.acc_op = ACC_LOAD;
        w.mul_op = MUL_KI_LO;
      end
      STEP_ACC_KL: begin
        w.acc_op = ACC_ADD;
        w.mul_op = MUL_KI_HI;
      end
      STEP_ACC_KH: w.acc_op = ACC_ADD_HI;
      STEP_OUT: begin
        w.wait_cond = WC_OUT_BUSY;
        w.ld_out    = 1'b1;
        w.jmp       = 1'b1;
        w.target    = STEP_WAIT;
      end
      default: begin
        w.jmp    = 1'b1;
        w.target = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== design/motor_speed_pi_controller.sv =====
// Top level of the motor speed PI controller: config registers, sequencer, datapath, output register.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one control tick per transaction:
//   encoder_count (signed counts seen this tick) and speed_ratio (signed Q1.15).
//   Output channel (out_valid/out_ready) returns one transaction per tick:
//   pwm_duty (0..PWM_MAX) and clamped (set when the PI sum was limited).
//   The config port writes one register per cycle while cfg_write_en is high;
//   cfg_index selects prop_gain, integ_gain, tick_period, count_to_speed,
//   max_target (0..4), other indexes are ignored. Write only while idle.
// Timing:
//   A 12-step microprogram drives one shared 33x33 multiplier, which sets the
//   rate: a new input is taken only after the program has passed all its steps
//   for the last one and loaded its result. in_ready is high only while the
//   program waits at its first step.
// Reset clears the integral and the previous error, loads the register
// defaults (about 1 ms period) and empties the output register. If the
// receiver stalls, the finished result holds in the output register and the
// program waits at its last step until that register frees up.
`default_nettype none
module motor_speed_pi_controller #(
  parameter int INTEGRAL_WIDTH = mspi_pkg::INTEGRAL_WIDTH_DEF,
  parameter int PWM_MAX        = mspi_pkg::PWM_MAX_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // config write port
  input  wire logic                              cfg_write_en,
  input  wire logic [mspi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mspi_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [15:0]                encoder_count,
  input  wire logic signed [15:0]                speed_ratio,
  // output channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [15:0]                            pwm_duty,
  output logic                                   clamped
);
  import mspi_pkg::*;

  cfg_regs_t   cfg;
  seq_ctrl_t   ctrl;
  logic        out_busy;
  logic [15:0] dp_duty;
  logic        dp_clamp;
  logic        out_load;

  // Configuration registers; unknown indexes fall through untouched.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain      <= '0;
      cfg.integ_gain     <= '0;
      cfg.tick_period    <= TICK_PERIOD_RST;
      cfg.count_to_speed <= COUNT_TO_SPEED_RST;
      cfg.max_target     <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_PROP_GAIN:      cfg.prop_gain      <= cfg_data;
        REG_INTEG_GAIN:     cfg.integ_gain     <= cfg_data;
        REG_TICK_PERIOD:    cfg.tick_period    <= cfg_data[30:0];
        REG_COUNT_TO_SPEED: cfg.count_to_speed <= cfg_data[30:0];
        REG_MAX_TARGET:     cfg.max_target     <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Output slot is busy when it holds a result the receiver is not taking now.
  assign out_busy = out_valid && !out_ready;

  mspi_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (in_valid),
    .out_busy (out_busy),
    .ctrl     (ctrl)
  );

  mspi_datapath #(
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH),
    .PWM_MAX        (PWM_MAX)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .cfg           (cfg),
    .encoder_count (encoder_count),
    .speed_ratio   (speed_ratio),
    .duty          (dp_duty),
    .clamp         (dp_clamp)
  );

  // Ready only while the program sits at its wait-for-input step.
  assign in_ready = (ctrl.cw.wait_cond == WC_NO_START);
  assign out_load = ctrl.fire && ctrl.cw.ld_out;

  // Output register parts the datapath from the receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pwm_duty <= dp_duty;
      clamped  <= dp_clamp;
    end
  end

  // One transaction in flight: right after an input is taken, no other is.
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a tick is in progress");

  // A new result never overwrites one the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  // A clamped result sits at one of the two limits.
  a_clamp_limits: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clamped) |-> (pwm_duty == 16'd0 || pwm_duty == 16'(PWM_MAX)))
    else $error("clamped duty not at a limit");

endmodule
`default_nettype wire

// ===== design/mspi_sequencer.sv =====
// Microcode sequencer: step counter, control store and stall/jump logic.
`default_nettype none
module mspi_sequencer (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic                out_busy,
  output mspi_pkg::seq_ctrl_t      ctrl
);
  import mspi_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ucode_word_t     cw;
  logic            stall;

  always_comb begin
    cw    = ucode_rom(pc);
    stall = ((cw.wait_cond == WC_NO_START) && !start) ||
            ((cw.wait_cond == WC_OUT_BUSY) && out_busy);
    if (stall) begin
      pc_next = pc;
    end else if (cw.jmp) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctrl.cw   = cw;
  assign ctrl.fire = !stall;

endmodule
`default_nettype wire

// ===== design/mspi_datapath.sv =====
// Datapath: shared 33x33 multiplier, error/integral registers, accumulator and output clamp.
`default_nettype none
module mspi_datapath #(
  parameter int INTEGRAL_WIDTH = mspi_pkg::INTEGRAL_WIDTH_DEF,
  parameter int PWM_MAX        = mspi_pkg::PWM_MAX_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mspi_pkg::seq_ctrl_t  ctrl,
  input  wire mspi_pkg::cfg_regs_t  cfg,
  input  wire logic signed [15:0]   encoder_count,
  input  wire logic signed [15:0]   speed_ratio,
  output logic             [15:0]   duty,
  output logic                      clamp
);
  import mspi_pkg::*;

  localparam int IW    = INTEGRAL_WIDTH;
  localparam int STW   = 41;                          // integral step width
  localparam int SW    = ((IW > STW) ? IW : STW) + 1; // saturating add width
  localparam int ACC_W = IW + 35;
  localparam int QW    = ACC_W - 32;

  localparam logic signed [SW-1:0] IMAX = {{(SW-IW+1){1'b0}}, {(IW-1){1'b1}}};
  localparam logic signed [SW-1:0] IMIN = ~IMAX;
  localparam logic signed [48:0]   ERR_MAX = 49'sd2147483647;
  localparam logic signed [48:0]   ERR_MIN = -49'sd2147483648;

  logic signed [15:0]      cnt_r;
  logic signed [15:0]      ratio_r;
  logic signed [65:0]      prod;
  logic signed [32:0]      tgt;
  logic signed [31:0]      err;
  logic signed [31:0]      prev_err;
  logic signed [32:0]      esum;
  logic signed [IW-1:0]    integ;
  logic signed [ACC_W-1:0] acc;

  logic signed [32:0]      mul_a;
  logic signed [32:0]      mul_b;
  logic signed [64:0]      integ_ext;
  logic signed [48:0]      diff;
  logic signed [31:0]      err_sat;
  logic signed [STW-1:0]   step;
  logic signed [SW-1:0]    integ_sum;
  logic signed [IW-1:0]    integ_next;
  logic signed [ACC_W-1:0] prod_ext;
  logic        [QW-1:0]    quot;

  assign integ_ext = 65'(integ);

  always_comb begin
    case (ctrl.cw.mul_op)
      MUL_TGT: begin
        mul_a = $signed({2'b00, cfg.max_target});
        mul_b = 33'(ratio_r);
      end
      MUL_MEAS: begin
        mul_a = 33'(cnt_r);
        mul_b = $signed({2'b00, cfg.count_to_speed});
      end
      MUL_DT: begin
        mul_a = esum;
        mul_b = $signed({2'b00, cfg.tick_period});
      end
      MUL_KP: begin
        mul_a = 33'($signed(cfg.prop_gain));
        mul_b = 33'(err);
      end
      MUL_KI_LO: begin
        mul_a = 33'($signed(cfg.integ_gain));
        mul_b = $signed({1'b0, integ_ext[31:0]});
      end
      MUL_KI_HI: begin
        mul_a = 33'($signed(cfg.integ_gain));
        mul_b = integ_ext[64:32];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // error = target - measured, saturated to 32 bits
  always_comb begin
    diff = 49'(tgt) - $signed(prod[48:0]);
    if (diff > ERR_MAX) begin
      err_sat = 32'sh7FFFFFFF;
    end else if (diff < ERR_MIN) begin
      err_sat = 32'sh80000000;
    end else begin
      err_sat = diff[31:0];
    end
  end

  // trapezoid step, floor via arithmetic shift, then saturating integrate
  always_comb begin
    step      = prod[65:25];
    integ_sum = SW'(integ) + SW'(step);
    if (integ_sum > IMAX) begin
      integ_next = IMAX[IW-1:0];
    end else if (integ_sum < IMIN) begin
      integ_next = IMIN[IW-1:0];
    end else begin
      integ_next = integ_sum[IW-1:0];
    end
  end

  assign prod_ext = ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (ctrl.fire && ctrl.cw.ld_in) begin
      cnt_r   <= encoder_count;
      ratio_r <= speed_ratio;
    end
    if (ctrl.cw.mul_op != MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
    if (ctrl.cw.ld_tgt) begin
      tgt <= prod[47:15];
    end
    if (ctrl.cw.ld_err) begin
      err <= err_sat;
    end
    if (ctrl.cw.ld_esum) begin
      esum <= 33'(err) + 33'(prev_err);
    end
    case (ctrl.cw.acc_op)
      ACC_LOAD:   acc <= prod_ext;
      ACC_ADD:    acc <= acc + prod_ext;
      ACC_ADD_HI: acc <= acc + (prod_ext <<< 32);
      default:    acc <= acc;
    endcase
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= '0;
      integ    <= '0;
    end else begin
      if (ctrl.cw.ld_esum) begin
        prev_err <= err;
      end
      if (ctrl.cw.ld_integ) begin
        integ <= integ_next;
      end
    end
  end

  // floor(sum / 2^32) clamped to 0..PWM_MAX
  always_comb begin
    quot = acc[ACC_W-1:32];
    if (acc[ACC_W-1]) begin
      duty  = '0;
      clamp = 1'b1;
    end else if (quot > QW'(PWM_MAX)) begin
      duty  = 16'(PWM_MAX);
      clamp = 1'b1;
    end else begin
      duty  = quot[15:0];
      clamp = 1'b0;
    end
  end

endmodule
`default_nettype wire
